/* hw/rtl/gwwb_pkg.sv */
// gray-world white balance: shared types and constants
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package gwwb_pkg;

    localparam int PIX_W   = 8;
    localparam int TDATA_W = 3 * PIX_W;

    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_TOTAL = 3'd1,
        ST_LOAD  = 3'd2,
        ST_DIV   = 3'd3,
        ST_STORE = 3'd4
    } state_t;

    typedef struct packed {
        logic  acc_en;
        logic  corr_en;
        logic  total_en;
        logic  load_en;
        logic  step_en;
        logic  store_en;
        logic  clear_en;
        chan_t chan;
    } ctrl_t;

    typedef struct packed {
        logic out_full;
    } stat_t;

endpackage

/* hw/rtl/gwwb_ctrl.sv */
// gray-world white balance: controller state machine
// depends on gwwb_pkg; drives the datapath through ctrl_t
`timescale 1ns / 1ps

module gwwb_ctrl
    import gwwb_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  logic  s_tuser,
    input  logic  s_tlast,
    input  logic  m_tready,
    input  stat_t stat,
    output logic  s_tready,
    output ctrl_t ctrl
);

    localparam int CNT_W = $clog2(STEPS);

    state_t           state_reg, state_next;
    chan_t            chan_reg, chan_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             last_step;

    assign s_tready  = (state_reg == ST_IDLE) && (!stat.out_full || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign last_step = (cnt_reg == CNT_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= CH_BLUE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !s_tuser && s_tlast)
                begin
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                state_next = ST_LOAD;
                chan_next  = CH_BLUE;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                case (chan_reg)
                    CH_BLUE:
                    begin
                        chan_next  = CH_GREEN;
                        state_next = ST_LOAD;
                    end
                    CH_GREEN:
                    begin
                        chan_next  = CH_RED;
                        state_next = ST_LOAD;
                    end
                    default:
                    begin
                        chan_next  = CH_BLUE;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.chan     = chan_reg;
        ctrl.acc_en   = accept && !s_tuser;
        ctrl.corr_en  = accept && s_tuser;
        ctrl.total_en = (state_reg == ST_TOTAL);
        ctrl.load_en  = (state_reg == ST_LOAD);
        ctrl.step_en  = (state_reg == ST_DIV);
        ctrl.store_en = (state_reg == ST_STORE);
        ctrl.clear_en = (state_reg == ST_STORE) && (chan_reg == CH_RED);
    end

endmodule

/* hw/rtl/gwwb_datapath.sv */
// gray-world white balance: sums, gain divider, gains and output register
// depends on gwwb_pkg; commanded by gwwb_ctrl
`timescale 1ns / 1ps

module gwwb_datapath
    import gwwb_pkg::*;
#(
    parameter int FRAME_PIXELS_LOG2 = 22,
    parameter int GAIN_FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               m_tready,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    output logic               m_tvalid,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    localparam int SUM_W     = FRAME_PIXELS_LOG2 + PIX_W;
    localparam int GAIN_BITS = PIX_W + GAIN_FRAC_BITS;
    localparam int TOT_W     = SUM_W + 2;
    localparam int DEN_W     = SUM_W + 2;
    localparam int D_W       = SUM_W + 3;
    localparam int N_W       = SUM_W + GAIN_FRAC_BITS + 4;
    localparam int TOP_W     = N_W - GAIN_BITS;
    localparam int P_W       = GAIN_BITS + PIX_W + 1;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic [P_W-1:0]       ROUND_C  = P_W'(1) << (GAIN_FRAC_BITS - 1);

    logic [SUM_W-1:0]     sum_b_reg, sum_g_reg, sum_r_reg;
    logic [TOT_W-1:0]     total_reg;
    logic [D_W-1:0]       d_reg, rem_reg;
    logic [GAIN_BITS-1:0] lo_reg, q_reg;
    logic                 sat_reg;
    logic [GAIN_BITS-1:0] gain_b_reg, gain_g_reg, gain_r_reg;
    logic [TDATA_W-1:0]   out_data_reg;
    logic                 out_last_reg;
    logic                 out_full_reg;

    logic [SUM_W-1:0]     chan_sum;
    logic [DEN_W-1:0]     den;
    logic [D_W-1:0]       d_val;
    logic [N_W-1:0]       n_val;
    logic [TOP_W-1:0]     n_top;
    logic [D_W:0]         rs;
    logic [D_W:0]         rs_diff;
    logic                 rs_ge;
    logic [GAIN_BITS-1:0] gain_val;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                  input logic [PIX_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(v);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0] smp,
                                                     input logic [GAIN_BITS-1:0] g);
        logic [P_W-1:0]                  p;
        logic [P_W-GAIN_FRAC_BITS-1:0]   hi;
        p  = P_W'(smp) * P_W'(g) + ROUND_C;
        hi = p[P_W-1:GAIN_FRAC_BITS];
        return (hi > (P_W - GAIN_FRAC_BITS)'(255)) ? {PIX_W{1'b1}} : hi[PIX_W-1:0];
    endfunction

    always_comb
    begin
        case (ctrl.chan)
            CH_BLUE:  chan_sum = sum_b_reg;
            CH_GREEN: chan_sum = sum_g_reg;
            CH_RED:   chan_sum = sum_r_reg;
            default:  chan_sum = '0;
        endcase
    end

    // den = 3 * sum, divisor = 2 * den, dividend = 2 * (total << frac) + den
    assign den     = DEN_W'(chan_sum) + {1'b0, chan_sum, 1'b0};
    assign d_val   = {den, 1'b0};
    assign n_val   = {1'b0, total_reg, {GAIN_FRAC_BITS{1'b0}}, 1'b0} + N_W'(den);
    assign n_top   = n_val[N_W-1:GAIN_BITS];
    assign rs      = {rem_reg, lo_reg[GAIN_BITS-1]};
    assign rs_diff = rs - {1'b0, d_reg};
    assign rs_ge   = (rs >= {1'b0, d_reg});
    assign gain_val = sat_reg ? {GAIN_BITS{1'b1}} : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_b_reg    <= '0;
            sum_g_reg    <= '0;
            sum_r_reg    <= '0;
            gain_b_reg   <= GAIN_ONE;
            gain_g_reg   <= GAIN_ONE;
            gain_r_reg   <= GAIN_ONE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_en)
            begin
                sum_b_reg <= '0;
                sum_g_reg <= '0;
                sum_r_reg <= '0;
            end
            else if (ctrl.acc_en)
            begin
                sum_b_reg <= sat_add(sum_b_reg, s_tdata[PIX_W-1:0]);
                sum_g_reg <= sat_add(sum_g_reg, s_tdata[2*PIX_W-1:PIX_W]);
                sum_r_reg <= sat_add(sum_r_reg, s_tdata[3*PIX_W-1:2*PIX_W]);
            end
            if (ctrl.store_en)
            begin
                case (ctrl.chan)
                    CH_BLUE:  gain_b_reg <= gain_val;
                    CH_GREEN: gain_g_reg <= gain_val;
                    CH_RED:   gain_r_reg <= gain_val;
                    default:  gain_r_reg <= gain_r_reg;
                endcase
            end
            if (ctrl.corr_en)
            begin
                out_full_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // channel total, restoring divider (one quotient bit per cycle) and output data
    always_ff @(posedge clk)
    begin
        if (ctrl.total_en)
        begin
            total_reg <= TOT_W'(sum_b_reg) + TOT_W'(sum_g_reg) + TOT_W'(sum_r_reg);
        end
        if (ctrl.load_en)
        begin
            d_reg   <= d_val;
            rem_reg <= {{(D_W - TOP_W){1'b0}}, n_top};
            lo_reg  <= n_val[GAIN_BITS-1:0];
            sat_reg <= ({{(D_W - TOP_W){1'b0}}, n_top} >= d_val);
            q_reg   <= '0;
        end
        else if (ctrl.step_en)
        begin
            rem_reg <= rs_ge ? rs_diff[D_W-1:0] : rs[D_W-1:0];
            lo_reg  <= {lo_reg[GAIN_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[GAIN_BITS-2:0], rs_ge};
        end
        if (ctrl.corr_en)
        begin
            out_data_reg <= {apply_gain(s_tdata[3*PIX_W-1:2*PIX_W], gain_r_reg),
                             apply_gain(s_tdata[2*PIX_W-1:PIX_W], gain_g_reg),
                             apply_gain(s_tdata[PIX_W-1:0], gain_b_reg)};
            out_last_reg <= s_tlast;
        end
    end

    assign stat.out_full = out_full_reg;
    assign m_tvalid      = out_full_reg;
    assign m_tdata       = out_data_reg;
    assign m_tlast       = out_last_reg;

endmodule

/* hw/rtl/gray_world_white_balance_core.sv */
// gray-world white balance: top level joining controller and datapath
// depends on gwwb_pkg, gwwb_ctrl and gwwb_datapath
//
// a frame is streamed in twice on the s_axis channel. s_axis_tuser low marks
// a statistics pixel: it is added to the per-channel sums and gives no output.
// the statistics pixel with s_axis_tlast high closes the pass: the three gains
// are then worked out by a shared one-bit-per-cycle divider, which keeps
// s_axis_tready low through the total, load, divide and store states, and the
// sums are cleared. s_axis_tuser high marks a correction pixel: each sample is
// scaled by its gain and appears on m_axis in the cycle after the transaction,
// with m_axis_tlast copied from s_axis_tlast. both passes take one pixel per
// cycle unless m_axis stalls. the output register is refilled in the cycle it
// is read, so a stalled receiver holds only the pixel behind it. reset sets
// all gains to unity and clears the sums and m_axis_tvalid.
`timescale 1ns / 1ps

module gray_world_white_balance_core
    import gwwb_pkg::*;
#(
    parameter int FRAME_PIXELS_LOG2 = 22,
    parameter int GAIN_FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // blue_in, green_in, red_in
    input  logic               s_axis_tuser,   // cmd
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // blue_out, green_out, red_out
    output logic               m_axis_tlast
);

    ctrl_t ctrl;
    stat_t stat;

    gwwb_ctrl #(
        .STEPS (PIX_W + GAIN_FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tuser  (s_axis_tuser),
        .s_tlast  (s_axis_tlast),
        .m_tready (m_axis_tready),
        .stat     (stat),
        .s_tready (s_axis_tready),
        .ctrl     (ctrl)
    );

    gwwb_datapath #(
        .FRAME_PIXELS_LOG2 (FRAME_PIXELS_LOG2),
        .GAIN_FRAC_BITS    (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .m_tready (m_axis_tready),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/gwwb_checker.sv */
// gray-world white balance: port-level checks over time
// depends on gwwb_pkg; bound to gray_world_white_balance_core
`timescale 1ns / 1ps

module gwwb_checker
    import gwwb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tuser,
    input logic               s_axis_tlast,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

    a_corr_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser |=> m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast)))
        else $error("correction transaction gave no output next cycle");

    a_stat_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("statistics transaction produced output");

    a_gain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !s_axis_tuser && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken while gains are being computed");

endmodule

bind gray_world_white_balance_core gwwb_checker u_gwwb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
